// ===== rtl/core/audio_fade_envelope_core_assert.svh =====
// assertion helpers, sampled on clk and held off while rst_n is low
`ifndef AUDIO_FADE_ENVELOPE_CORE_ASSERT_SVH
`define AUDIO_FADE_ENVELOPE_CORE_ASSERT_SVH

// same-cycle implication
`define AFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/afe_pkg.sv =====
package afe_pkg;

    localparam int CHANNELS    = 4;
    localparam int SAMPLE_BITS = 24;
    localparam int POS_BITS    = 24;
    localparam int GAIN_BITS   = 16;
    localparam int PHASE_BITS  = 16;
    localparam int DIV_DEPTH   = PHASE_BITS;
    localparam int SQRT_STEPS  = 16;
    localparam int CURVE_DEPTH = SQRT_STEPS + 1;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE = 16'h8000;

    localparam logic [2:0] CURVE_LINEAR  = 3'd0;
    localparam logic [2:0] CURVE_SQUARED = 3'd1;
    localparam logic [2:0] CURVE_SCURVE  = 3'd2;
    localparam logic [2:0] CURVE_SQRT    = 3'd3;
    localparam logic [2:0] CURVE_UNITY   = 3'd4;

    localparam logic [2:0] REG_FADE_IN_LEN   = 3'd0;
    localparam logic [2:0] REG_FADE_OUT_LEN  = 3'd1;
    localparam logic [2:0] REG_FADE_IN_CURVE = 3'd2;
    localparam logic [2:0] REG_FADE_OUT_CURVE = 3'd3;
    localparam logic [2:0] REG_CLIP_LEN      = 3'd4;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd5;

    typedef struct packed {
        logic        [POS_BITS-1:0]    position;
        logic signed [SAMPLE_BITS-1:0] sample_0;
        logic signed [SAMPLE_BITS-1:0] sample_1;
        logic signed [SAMPLE_BITS-1:0] sample_2;
        logic signed [SAMPLE_BITS-1:0] sample_3;
    } frame_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_0;
        logic signed [SAMPLE_BITS-1:0] out_1;
        logic signed [SAMPLE_BITS-1:0] out_2;
        logic signed [SAMPLE_BITS-1:0] out_3;
    } result_t;

endpackage

// ===== rtl/core/afe_divider.sv =====
module afe_divider #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [LENGTH_BITS-1:0]               offset,
    input  logic [LENGTH_BITS-1:0]               len,
    output logic [afe_pkg::PHASE_BITS-1:0]       phase
);
    import afe_pkg::*;

    // one quotient bit per stage; remainder stays below len while offset is below len
    logic [LENGTH_BITS-1:0] rem_reg  [DIV_DEPTH];
    logic [LENGTH_BITS-1:0] rem_next [DIV_DEPTH];
    logic [PHASE_BITS-1:0]  quo_reg  [DIV_DEPTH];
    logic [PHASE_BITS-1:0]  quo_next [DIV_DEPTH];
    logic [LENGTH_BITS:0]   shifted  [DIV_DEPTH];
    logic                   fits     [DIV_DEPTH];

    always_comb
    begin
        for (int i = 0; i < DIV_DEPTH; i++)
        begin
            if (i == 0)
            begin
                shifted[i] = {offset, 1'b0};
            end
            else
            begin
                shifted[i] = {rem_reg[i-1], 1'b0};
            end
            fits[i] = shifted[i] >= {1'b0, len};
            if (fits[i])
            begin
                rem_next[i] = LENGTH_BITS'(shifted[i] - {1'b0, len});
            end
            else
            begin
                rem_next[i] = shifted[i][LENGTH_BITS-1:0];
            end
            if (i == 0)
            begin
                quo_next[i] = {{(PHASE_BITS-1){1'b0}}, fits[i]};
            end
            else
            begin
                quo_next[i] = {quo_reg[i-1][PHASE_BITS-2:0], fits[i]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign phase = quo_reg[DIV_DEPTH-1];

endmodule

// ===== rtl/core/afe_curve.sv =====
module afe_curve (
    input  logic                           clk,
    input  logic                           en,
    input  logic                           rising,
    input  logic [2:0]                     code,
    input  logic [afe_pkg::PHASE_BITS-1:0] phase,
    output logic [afe_pkg::GAIN_BITS-1:0]  gain
);
    import afe_pkg::*;

    typedef enum logic [2:0] {K_LIN, K_SQ, K_SC, K_SQRT, K_UNITY} kind_t;

    // stage 0: operand select and square
    logic [16:0] u, c, m;
    logic [17:0] r_sc;
    logic        lower;
    kind_t       kind;
    logic [15:0] lin;

    kind_t       kind_reg;
    logic [33:0] sq_reg;
    logic [15:0] lin_reg;
    logic        pickq_reg;

    // sqrt iterations
    logic [31:0] sv_reg [SQRT_STEPS+1];
    logic [31:0] sr_reg [SQRT_STEPS+1];
    logic [31:0] sv_next [SQRT_STEPS+1];
    logic [31:0] sr_next [SQRT_STEPS+1];
    logic [31:0] trial [SQRT_STEPS];

    logic [GAIN_BITS-1:0] gp_reg  [SQRT_STEPS];
    logic [GAIN_BITS-1:0] gp_next [SQRT_STEPS];
    logic                 us_reg  [SQRT_STEPS];
    logic                 us_next [SQRT_STEPS];
    logic [GAIN_BITS-1:0] gain_pre;
    logic [16:0]          q17;

    always_comb
    begin
        u     = {1'b0, phase};
        c     = 17'h10000 - u;
        lower = !phase[PHASE_BITS-1];
        r_sc  = 18'h20000 - {1'b0, phase, 1'b0};
        unique case (code)
            CURVE_SQUARED: kind = K_SQ;
            CURVE_SCURVE:  kind = K_SC;
            CURVE_SQRT:    kind = K_SQRT;
            CURVE_UNITY:   kind = K_UNITY;
            default:       kind = K_LIN;
        endcase
        if (kind == K_SC)
        begin
            m = lower ? {phase, 1'b0} : r_sc[16:0];
        end
        else
        begin
            m = rising ? c : u;
        end
        lin = rising ? {1'b0, phase[PHASE_BITS-1:1]} : c[16:1];
    end

    // stage 1: gain from the square; later stages: sqrt steps and the gain delay line
    always_comb
    begin
        sv_next[0] = {1'b0, (rising ? u : c), 14'b0};
        sr_next[0] = '0;
        q17 = '0;
        unique case (kind_reg)
            K_SQ:
            begin
                q17 = sq_reg[33:17];
                gain_pre = GAIN_BITS'(17'(GAIN_ONE) - q17);
            end
            K_SC:
            begin
                q17 = {1'b0, sq_reg[33:18]};
                gain_pre = pickq_reg ? GAIN_BITS'(q17) : GAIN_BITS'(17'(GAIN_ONE) - q17);
            end
            K_UNITY: gain_pre = GAIN_ONE;
            K_LIN:   gain_pre = lin_reg;
            default: gain_pre = '0;
        endcase
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            if (k == 0)
            begin
                gp_next[k] = gain_pre;
                us_next[k] = kind_reg == K_SQRT;
            end
            else
            begin
                gp_next[k] = gp_reg[k-1];
                us_next[k] = us_reg[k-1];
            end
        end
        for (int j = 0; j < SQRT_STEPS; j++)
        begin
            trial[j] = sr_reg[j] + (32'd1 << (30 - 2 * j));
            if (sv_reg[j] >= trial[j])
            begin
                sv_next[j+1] = sv_reg[j] - trial[j];
                sr_next[j+1] = (sr_reg[j] >> 1) + (32'd1 << (30 - 2 * j));
            end
            else
            begin
                sv_next[j+1] = sv_reg[j];
                sr_next[j+1] = sr_reg[j] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg  <= kind;
            sq_reg    <= m * m;
            lin_reg   <= lin;
            pickq_reg <= (rising == lower);
            sv_reg    <= sv_next;
            sr_reg    <= sr_next;
            gp_reg    <= gp_next;
            us_reg    <= us_next;
        end
    end

    assign gain = us_reg[SQRT_STEPS-1] ? sr_reg[SQRT_STEPS][GAIN_BITS-1:0]
                                       : gp_reg[SQRT_STEPS-1];

endmodule

// ===== rtl/core/afe_lane.sv =====
module afe_lane (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic                                   active,
    input  logic                                   do_in,
    input  logic                                   do_out,
    input  logic [afe_pkg::GAIN_BITS-1:0]          gain_in,
    input  logic [afe_pkg::GAIN_BITS-1:0]          gain_out,
    input  logic signed [afe_pkg::SAMPLE_BITS-1:0] sample,
    output logic signed [afe_pkg::SAMPLE_BITS-1:0] faded
);
    import afe_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;

    logic signed [PROD_BITS-1:0]   p1, p2;
    logic signed [SAMPLE_BITS-1:0] s1_reg, s2_reg;
    logic [GAIN_BITS-1:0]          gout_reg;
    logic                          out_on_reg;

    // floor shift by 15 is the arithmetic slice above bit 14
    assign p1 = sample * $signed({1'b0, gain_in});
    assign p2 = s1_reg * $signed({1'b0, gout_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg     <= (active && do_in) ? p1[15 +: SAMPLE_BITS] : sample;
            gout_reg   <= gain_out;
            out_on_reg <= active && do_out;
            s2_reg     <= out_on_reg ? p2[15 +: SAMPLE_BITS] : s1_reg;
        end
    end

    assign faded = s2_reg;

endmodule

// ===== rtl/core/audio_fade_envelope_core.sv =====
// pipeline from an accepted frame to its result: 1 input stage, 16 divider
// stages, 17 curve stages, 2 gain multiply stages per lane
// throughput: one frame per cycle while no result is held by result_stall, set by
// the bit-per-stage phase divider and the step-per-stage square root, both fully pipelined
// reset: valid bits cleared, configuration registers back to their defaults (channel_count 2)
module audio_fade_envelope_core #(
    parameter int LENGTH_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    input  logic            frame_valid,
    output logic            frame_stall,
    input  afe_pkg::frame_t frame,
    output logic            result_valid,
    input  logic            result_stall,
    output afe_pkg::result_t result
);
    import afe_pkg::*;

    `include "audio_fade_envelope_core_assert.svh"

    localparam int DELAY = DIV_DEPTH + CURVE_DEPTH;
    localparam int DEPTH = DELAY + 3;

    typedef struct packed {
        logic                          do_in;
        logic                          do_out;
        logic signed [SAMPLE_BITS-1:0] s0;
        logic signed [SAMPLE_BITS-1:0] s1;
        logic signed [SAMPLE_BITS-1:0] s2;
        logic signed [SAMPLE_BITS-1:0] s3;
    } carry_t;

    // configuration registers
    logic [LENGTH_BITS-1:0] fade_in_length_reg;
    logic [LENGTH_BITS-1:0] fade_out_length_reg;
    logic [2:0]             fade_in_curve_reg;
    logic [2:0]             fade_out_curve_reg;
    logic [POS_BITS-1:0]    clip_length_reg;
    logic [2:0]             channel_count_reg;
    logic                   wr_en;
    logic [2:0]             wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_in_length_reg  <= '0;
            fade_out_length_reg <= '0;
            fade_in_curve_reg   <= CURVE_LINEAR;
            fade_out_curve_reg  <= CURVE_LINEAR;
            clip_length_reg     <= '0;
            channel_count_reg   <= 3'd2;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_FADE_IN_LEN:    fade_in_length_reg  <= pwdata[LENGTH_BITS-1:0];
                REG_FADE_OUT_LEN:   fade_out_length_reg <= pwdata[LENGTH_BITS-1:0];
                REG_FADE_IN_CURVE:  fade_in_curve_reg   <= pwdata[2:0];
                REG_FADE_OUT_CURVE: fade_out_curve_reg  <= pwdata[2:0];
                REG_CLIP_LEN:       clip_length_reg     <= pwdata[POS_BITS-1:0];
                REG_CHANNEL_COUNT:  channel_count_reg   <= pwdata[2:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (wr_idx)
            REG_FADE_IN_LEN:    prdata = 32'(fade_in_length_reg);
            REG_FADE_OUT_LEN:   prdata = 32'(fade_out_length_reg);
            REG_FADE_IN_CURVE:  prdata = 32'(fade_in_curve_reg);
            REG_FADE_OUT_CURVE: prdata = 32'(fade_out_curve_reg);
            REG_CLIP_LEN:       prdata = 32'(clip_length_reg);
            REG_CHANNEL_COUNT:  prdata = 32'(channel_count_reg);
            default:            prdata = '0;
        endcase
    end

    // whole pipeline moves together; it holds only while a result waits
    logic             en;
    logic [DEPTH-1:0] vld_reg;

    assign en           = !(result_valid && result_stall);
    assign frame_stall  = !en;
    assign result_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], frame_valid};
        end
    end

    // input stage: region decode and fade offsets
    logic [POS_BITS:0]      out_end;
    logic                   do_in, do_out;
    logic [LENGTH_BITS-1:0] off_out;
    logic [LENGTH_BITS-1:0] off_in_reg, off_out_reg;
    carry_t                 head_reg;
    carry_t                 dl_reg [DELAY];

    assign out_end = {1'b0, frame.position} + (POS_BITS+1)'(fade_out_length_reg);
    assign do_in   = frame.position < POS_BITS'(fade_in_length_reg);
    assign do_out  = (fade_out_length_reg != '0) && (frame.position < clip_length_reg)
                     && (out_end >= {1'b0, clip_length_reg});
    assign off_out = LENGTH_BITS'(out_end - {1'b0, clip_length_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            off_in_reg      <= frame.position[LENGTH_BITS-1:0];
            off_out_reg     <= off_out;
            head_reg.do_in  <= do_in;
            head_reg.do_out <= do_out;
            head_reg.s0     <= frame.sample_0;
            head_reg.s1     <= frame.sample_1;
            head_reg.s2     <= frame.sample_2;
            head_reg.s3     <= frame.sample_3;
            dl_reg[0]       <= head_reg;
            for (int i = 1; i < DELAY; i++)
            begin
                dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    // phase of each fade
    logic [PHASE_BITS-1:0] t_in, t_out;
    logic [GAIN_BITS-1:0]  gain_in, gain_out;

    afe_divider #(.LENGTH_BITS(LENGTH_BITS)) u_div_in (
        .clk(clk), .en(en), .offset(off_in_reg), .len(fade_in_length_reg), .phase(t_in)
    );

    afe_divider #(.LENGTH_BITS(LENGTH_BITS)) u_div_out (
        .clk(clk), .en(en), .offset(off_out_reg), .len(fade_out_length_reg), .phase(t_out)
    );

    // gain curves, rising for fade-in and falling for fade-out
    afe_curve u_curve_in (
        .clk(clk), .en(en), .rising(1'b1), .code(fade_in_curve_reg),
        .phase(t_in), .gain(gain_in)
    );

    afe_curve u_curve_out (
        .clk(clk), .en(en), .rising(1'b0), .code(fade_out_curve_reg),
        .phase(t_out), .gain(gain_out)
    );

    // one lane per channel; lanes past channel_count pass through
    logic signed [SAMPLE_BITS-1:0] lane_in  [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] lane_out [CHANNELS];
    carry_t                        tail;

    assign tail       = dl_reg[DELAY-1];
    assign lane_in[0] = tail.s0;
    assign lane_in[1] = tail.s1;
    assign lane_in[2] = tail.s2;
    assign lane_in[3] = tail.s3;

    for (genvar ch = 0; ch < CHANNELS; ch++)
    begin : g_lane
        afe_lane u_lane (
            .clk(clk), .en(en),
            .active(3'(ch) < channel_count_reg),
            .do_in(tail.do_in), .do_out(tail.do_out),
            .gain_in(gain_in), .gain_out(gain_out),
            .sample(lane_in[ch]), .faded(lane_out[ch])
        );
    end

    // merge lanes into the result request
    assign result.out_0 = lane_out[0];
    assign result.out_1 = lane_out[1];
    assign result.out_2 = lane_out[2];
    assign result.out_3 = lane_out[3];

    // gains are checked only where a request sits at the lane inputs
    `AFE_ASSERT_NOW(a_block_when_full, result_valid && result_stall, frame_stall,
        "input taken while result blocked")
    `AFE_ASSERT_NEXT(a_freeze, !en, $stable(vld_reg), "pipeline moved while frozen")
    `AFE_ASSERT_NOW(a_gain_in_max, vld_reg[DELAY], gain_in <= GAIN_ONE, "fade-in gain above unity")
    `AFE_ASSERT_NOW(a_gain_out_max, vld_reg[DELAY], gain_out <= GAIN_ONE, "fade-out gain above unity")

endmodule

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import afe_pkg::*;

    // q1.15 fade gain arithmetic, one frame at a time
    class fade_scoreboard;
        logic [15:0] in_len;
        logic [15:0] out_len;
        logic [2:0]  in_curve;
        logic [2:0]  out_curve;
        logic [23:0] clip_len;
        logic [2:0]  lanes;
        result_t     pending[$];
        int          errors;

        function new();
            in_len = '0;
            out_len = '0;
            in_curve = CURVE_LINEAR;
            out_curve = CURVE_LINEAR;
            clip_len = '0;
            lanes = 3'd2;
            errors = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            r = 0;
            for (longint unsigned b = 64'd1 << 30; b != 0; b = b >> 2)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
            end
            return r;
        endfunction

        function longint unsigned gain(logic [2:0] code, longint unsigned t, bit rising);
            longint unsigned c;
            longint unsigned w;
            longint unsigned q;
            c = 65536 - t;
            case (code)
                CURVE_SQUARED: return rising ? 32768 - ((c * c) >> 17) : 32768 - ((t * t) >> 17);
                CURVE_SCURVE:
                begin
                    if (t < 32768)
                    begin
                        w = 2 * t;
                        q = (w * w) >> 18;
                        return rising ? q : 32768 - q;
                    end
                    w = 131072 - 2 * t;
                    q = (w * w) >> 18;
                    return rising ? 32768 - q : q;
                end
                CURVE_SQRT: return int_sqrt(rising ? (t << 14) : (c << 14));
                CURVE_UNITY: return 32768;
                default: return rising ? t >> 1 : c >> 1;
            endcase
        endfunction

        function void note_frame(frame_t f);
            longint unsigned p;
            longint unsigned gi;
            longint unsigned go;
            longint s;
            bit in_zone;
            bit out_zone;
            logic [23:0] smp[4];
            logic [23:0] o[4];
            p = f.position;
            in_zone = p < in_len;
            out_zone = out_len != 0 && p < clip_len && p + out_len >= clip_len;
            gi = in_zone ? gain(in_curve, (p << 16) / in_len, 1) : 32768;
            go = out_zone ? gain(out_curve, ((p + out_len - clip_len) << 16) / out_len, 0)
                          : 32768;
            smp = '{f.sample_0, f.sample_1, f.sample_2, f.sample_3};
            for (int ch = 0; ch < 4; ch++)
            begin
                s = longint'(signed'(smp[ch]));
                if (ch < lanes)
                begin
                    // arithmetic shift floors toward minus infinity
                    if (in_zone)
                        s = (s * longint'(gi)) >>> 15;
                    if (out_zone)
                        s = (s * longint'(go)) >>> 15;
                end
                o[ch] = s[23:0];
            end
            pending.push_back('{o[0], o[1], o[2], o[3]});
        endfunction

        function void check_result(result_t r);
            result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, r);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r.out_0 !== e.out_0) begin $display("%0t: out_0 exp %h got %h", $time, e.out_0, r.out_0); errors++; end
            if (r.out_1 !== e.out_1) begin $display("%0t: out_1 exp %h got %h", $time, e.out_1, r.out_1); errors++; end
            if (r.out_2 !== e.out_2) begin $display("%0t: out_2 exp %h got %h", $time, e.out_2, r.out_2); errors++; end
            if (r.out_3 !== e.out_3) begin $display("%0t: out_3 exp %h got %h", $time, e.out_3, r.out_3); errors++; end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [4:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    logic        frame_valid = 0;
    logic        frame_stall;
    frame_t      frame = '0;
    logic        result_valid;
    logic        result_stall = 0;
    result_t     result;

    fade_scoreboard board = new();
    bit          hold_off = 0;  // long receiver hold-off requested

    audio_fade_envelope_core u_dut (.*);

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // gap length: mostly short, a few long
    function int gap_len();
        if ($urandom_range(0, 9) < 4) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    // apb write, setup then access
    task write_reg(logic [2:0] idx, logic [31:0] v);
        @(posedge clk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_FADE_IN_LEN:    board.in_len = v[15:0];
            REG_FADE_OUT_LEN:   board.out_len = v[15:0];
            REG_FADE_IN_CURVE:  board.in_curve = v[2:0];
            REG_FADE_OUT_CURVE: board.out_curve = v[2:0];
            REG_CLIP_LEN:       board.clip_len = v[23:0];
            default:            board.lanes = v[2:0];
        endcase
    endtask

    task send_frame(frame_t f, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            frame_valid <= 0;
            repeat (g) @(posedge clk);
        end
        frame_valid <= 1;
        frame <= f;
        do @(posedge clk); while (frame_stall);
        board.note_frame(f);
    endtask

    task drain();
        frame_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function logic [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2: return 24'hffffff;
            3: return 24'h000001;
            default: return 24'($urandom());
        endcase
    endfunction

    // positions cluster near the fade edges so both regions get hit
    function logic [23:0] rand_position();
        case ($urandom_range(0, 5))
            0: return 24'($urandom_range(0, board.in_len + 2));
            1: return 24'(board.clip_len - $urandom_range(0, board.out_len + 2));
            2: return 24'(board.clip_len + $urandom_range(0, 3));
            3: return 24'($urandom());
            default: return 24'($urandom_range(0, board.clip_len + 4));
        endcase
    endfunction

    function frame_t rand_frame();
        return '{rand_position(), rand_sample(), rand_sample(), rand_sample(), rand_sample()};
    endfunction

    // receiver: random stalls, one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off)
            result_stall <= 1;
        else if ($urandom_range(0, 9) < 3)
            result_stall <= ($urandom_range(0, 29) != 0) || 1'b1;
        else
            result_stall <= 0;
        if (result_valid && !result_stall)
            board.check_result(result);
    end

    initial
    begin
        logic [15:0] il;
        logic [15:0] ol;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset config, extremes of the fields
        send_frame('{24'd0, 24'h7fffff, 24'h800000, 24'h123456, 24'hfedcba}, 0);
        drain();
        write_reg(REG_FADE_IN_LEN, 16);
        write_reg(REG_FADE_OUT_LEN, 16);
        write_reg(REG_CLIP_LEN, 40);
        write_reg(REG_CHANNEL_COUNT, 4);
        for (int c = 0; c < 8; c++)
        begin
            drain();
            write_reg(REG_FADE_IN_CURVE, c);
            write_reg(REG_FADE_OUT_CURVE, 7 - c);
            send_frame('{24'd0, 24'h7fffff, 24'h800000, 24'hffffff, 24'h000001}, 0);
            send_frame('{24'd9, 24'h7fffff, 24'h800000, 24'hffffff, 24'h400000}, 0);
            send_frame('{24'd30, 24'h7fffff, 24'h800000, 24'h000001, 24'hc00000}, 0);
        end
        // fade-out longer than clip, channel count zero then over range
        drain();
        write_reg(REG_CLIP_LEN, 10);
        write_reg(REG_CHANNEL_COUNT, 0);
        send_frame('{24'd3, 24'h7fffff, 24'h800000, 24'h1, 24'h2}, 0);
        send_frame('{24'hffffff, 24'h7fffff, 24'h800000, 24'h1, 24'h2}, 0);
        drain();
        write_reg(REG_CHANNEL_COUNT, 7);
        send_frame('{24'd3, 24'h7fffff, 24'h800000, 24'h1, 24'h2}, 0);
        send_frame('{24'd10, 24'h7fffff, 24'h800000, 24'h1, 24'h2}, 0);

        // random phases with varied settings
        for (int ph = 0; ph < 13; ph++)
        begin
            drain();
            case (ph)
                0: begin il = 16'hffff; ol = 16'hffff; end
                1: begin il = 16'd1; ol = 16'd1; end
                2: begin il = '0; ol = '0; end
                default:
                begin
                    il = 16'($urandom_range(1, 300));
                    ol = 16'($urandom_range(1, 300));
                end
            endcase
            write_reg(REG_FADE_IN_LEN, il);
            write_reg(REG_FADE_OUT_LEN, ol);
            write_reg(REG_FADE_IN_CURVE, $urandom_range(0, 7));
            write_reg(REG_FADE_OUT_CURVE, $urandom_range(0, 7));
            write_reg(REG_CLIP_LEN, ph == 0 ? 24'hffffff : (ph == 2 ? 0 : $urandom_range(0, 700)));
            write_reg(REG_CHANNEL_COUNT, $urandom_range(0, 7));
            if (ph == 4)
                hold_off = 1;
            for (int n = 0; n < 100; n++)
                send_frame(rand_frame(), ph != 4 && ($urandom_range(0, 3) != 0 || ph > 8));
            hold_off = 0;
        end

        drain();
        if (board.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // long receiver hold-off, counted here while frames keep coming
    always @(posedge clk)
    begin
        if (hold_off)
        begin
            repeat (150) @(posedge clk);
            hold_off = 0;
        end
    end

    initial
    begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== audio_fade_envelope_core.f =====
+incdir+rtl/core
rtl/core/afe_pkg.sv
rtl/core/afe_divider.sv
rtl/core/afe_curve.sv
rtl/core/afe_lane.sv
rtl/core/audio_fade_envelope_core.sv
test/testbench.sv
